// ----- sv/vct_pkg.sv -----
// vct_pkg: types and constants for the vertex clip transform.
// Standalone; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package vct_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int ROW_W     = 64;
    localparam int CLIP_W    = 34;   // Q16.16 dot product, |value| < 2^33
    localparam int REM_W     = CLIP_W + 12;
    localparam int CMP_W     = CLIP_W + 16;
    localparam int Q_W       = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 4'd0,
        REG_ROW1 = 4'd1,
        REG_ROW2 = 4'd2,
        REG_ROW3 = 4'd3
    } cfg_reg_t;

    typedef logic [ROW_W-1:0] mat_row_t;

    localparam mat_row_t ROW_RESET [4] = '{
        64'd4254466048,
        64'd2654289788928,
        64'd160159261748428487,
        64'd256
    };

    // State carried through the divider stages, one lane per x/y/z.
    typedef struct packed {
        logic [2:0][REM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   quo;
        logic [CLIP_W-1:0]     den;
        logic [2:0]            neg;
        logic [2:0]            ovf;
        logic                  wz;
    } div_t;

endpackage

`default_nettype wire

// ----- sv/vct_if.sv -----
// Channel interfaces of the vertex clip transform: point in, ndc out, config writes.
// Depends on vct_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vct_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic signed [15:0] world_z;

    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface vct_ndc_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic signed [15:0] ndc_z;
    logic               w_zero;
    logic               saturated;

    modport source (output valid, ndc_x, ndc_y, ndc_z, w_zero, saturated, input ready);
    modport sink   (input valid, ndc_x, ndc_y, ndc_z, w_zero, saturated, output ready);
endinterface

interface vct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vct_pkg::CFG_IDX_W-1:0]  index;
    logic [vct_pkg::ROW_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/vertex_clip_transform.sv -----
// vertex_clip_transform: 4x4 matrix transform of a Q8.8 point and divide by w to Q4.12.
// Depends on vct_pkg and the interfaces in vct_if.sv.
//
// Channels: point (sink) carries world_x/y/z, ndc (source) carries ndc_x/y/z,
// w_zero and saturated, cfg (sink) writes one 64-bit matrix row per beat;
// index 0..3 selects the row, other indexes are dropped. cfg is always ready
// and must only be written while no point is in flight.
// Throughput: one point per cycle when ndc does not stall. Stages: 1 multiply
// (12 products), 2 add, 1 abs/range check, 16 restoring divide steps (one
// quotient bit each, three lanes sharing w), 1 saturate/output register.
// Each stage moves on when the stage after it is empty or moving, so a stall
// on ndc fills bubbles first and input stays ready until every stage holds
// a point. Nothing is dropped or duplicated.
// Reset: all stage valids clear and the matrix returns to its default rows.
`timescale 1ns / 1ps
`default_nettype none

module vertex_clip_transform (
    input  wire         clk,
    input  wire         rst_n,
    vct_point_if.sink   point,
    vct_ndc_if.source   ndc,
    vct_cfg_if.sink     cfg
);

    localparam int ST_MUL  = 0;
    localparam int ST_ADD1 = 1;
    localparam int ST_ADD2 = 2;
    localparam int ST_PREP = 3;
    localparam int N_DIV   = vct_pkg::Q_W;
    localparam int ST_OUT  = ST_PREP + N_DIV + 1;
    localparam int N_ST    = ST_OUT + 1;

    localparam int CW = vct_pkg::CLIP_W;
    localparam int RW = vct_pkg::REM_W;
    localparam int PW = vct_pkg::CMP_W;

    // ---------------- config ----------------
    vct_pkg::mat_row_t row_reg [4];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                row_reg[r] <= vct_pkg::ROW_RESET[r];
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                vct_pkg::REG_ROW0: row_reg[0] <= cfg.data;
                vct_pkg::REG_ROW1: row_reg[1] <= cfg.data;
                vct_pkg::REG_ROW2: row_reg[2] <= cfg.data;
                vct_pkg::REG_ROW3: row_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- stage control ----------------
    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] vld_next;
    logic [N_ST-1:0] adv;

    assign adv[ST_OUT] = !vld_reg[ST_OUT] || ndc.ready;
    generate
        for (genvar k = 0; k < ST_OUT; k++)
        begin : g_adv
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end
    endgenerate

    assign point.ready = adv[ST_MUL];

    always_comb
    begin
        vld_next[ST_MUL] = adv[ST_MUL] ? point.valid : vld_reg[ST_MUL];
        for (int k = ST_MUL + 1; k < N_ST; k++)
        begin
            if (!adv[k])
                vld_next[k] = vld_reg[k];
            else
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ---------------- multiply ----------------
    logic signed [15:0] wv [3];
    logic signed [31:0] prod_reg [4][3];

    assign wv[0] = point.world_x;
    assign wv[1] = point.world_y;
    assign wv[2] = point.world_z;

    always_ff @(posedge clk)
    begin
        if (adv[ST_MUL])
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= $signed(row_reg[r][16*c +: 16]) * wv[c];
                end
            end
        end
    end

    // ---------------- add tree ----------------
    logic signed [CW-1:0] bias [4];
    logic signed [CW-1:0] suma_reg [4];
    logic signed [CW-1:0] sumb_reg [4];
    logic signed [CW-1:0] clip_reg [4];

    // translation column times homogeneous 1.0 (256 in Q8.8)
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            bias[r] = {{(CW-24){row_reg[r][63]}}, row_reg[r][63:48], 8'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_ADD1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                suma_reg[r] <= CW'(prod_reg[r][0]) + CW'(prod_reg[r][1]);
                sumb_reg[r] <= CW'(prod_reg[r][2]) + bias[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_ADD2])
        begin
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= suma_reg[r] + sumb_reg[r];
            end
        end
    end

    // ---------------- divide prep ----------------
    vct_pkg::div_t dst_reg  [N_DIV+1];
    vct_pkg::div_t dst_next [N_DIV+1];

    always_comb
    begin
        logic [CW-1:0] wmag;
        logic [CW-1:0] cmag;
        wmag = clip_reg[3][CW-1] ? CW'(-clip_reg[3]) : CW'(clip_reg[3]);
        dst_next[0].den = wmag;
        dst_next[0].wz  = (clip_reg[3] == '0);
        for (int c = 0; c < 3; c++)
        begin
            cmag = clip_reg[c][CW-1] ? CW'(-clip_reg[c]) : CW'(clip_reg[c]);
            dst_next[0].neg[c] = clip_reg[c][CW-1] ^ clip_reg[3][CW-1];
            // quotient >= 2^16 when |c| >= 16*|w|
            dst_next[0].ovf[c] = ({4'b0, cmag} >= {wmag, 4'b0});
            dst_next[0].rem[c] = {cmag, 12'b0};
            dst_next[0].quo[c] = '0;
        end
    end

    // ---------------- divide steps ----------------
    generate
        for (genvar d = 1; d <= N_DIV; d++)
        begin : g_div
            always_comb
            begin
                logic [PW-1:0] sden;
                logic [PW-1:0] wrem;
                logic          ge;
                dst_next[d] = dst_reg[d-1];
                sden = PW'(dst_reg[d-1].den) << (N_DIV - d);
                for (int c = 0; c < 3; c++)
                begin
                    wrem = PW'(dst_reg[d-1].rem[c]);
                    ge = (wrem >= sden);
                    dst_next[d].rem[c] = ge ? RW'(wrem - sden) : dst_reg[d-1].rem[c];
                    dst_next[d].quo[c] = {dst_reg[d-1].quo[c][vct_pkg::Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int d = 0; d <= N_DIV; d++)
        begin
            if (adv[ST_PREP + d])
                dst_reg[d] <= dst_next[d];
        end
    end

    // ---------------- saturate and output ----------------
    logic [2:0][15:0] res_next;
    logic             sat_next;
    logic [2:0][15:0] res_reg;
    logic             wz_reg;
    logic             sat_reg;

    always_comb
    begin
        vct_pkg::div_t fin;
        logic [15:0] q;
        fin = dst_reg[N_DIV];
        sat_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            q = fin.quo[c];
            if (fin.wz)
                res_next[c] = '0;
            else if (fin.ovf[c] || (fin.neg[c] ? (q[15] && |q[14:0]) : q[15]))
            begin
                res_next[c] = fin.neg[c] ? 16'h8000 : 16'h7FFF;
                sat_next = 1'b1;
            end
            else
                res_next[c] = fin.neg[c] ? 16'(-q) : q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            res_reg <= res_next;
            wz_reg  <= dst_reg[N_DIV].wz;
            sat_reg <= sat_next;
        end
    end

    assign ndc.valid     = vld_reg[ST_OUT];
    assign ndc.ndc_x     = res_reg[0];
    assign ndc.ndc_y     = res_reg[1];
    assign ndc.ndc_z     = res_reg[2];
    assign ndc.w_zero    = wz_reg;
    assign ndc.saturated = sat_reg;

    // ---------------- checks ----------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> vld_reg[ST_MUL])
        else $error("accepted beat did not enter multiply stage");

    a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ndc.valid && ndc.w_zero |-> ndc.ndc_x == '0 && ndc.ndc_y == '0
            && ndc.ndc_z == '0 && !ndc.saturated)
        else $error("w_zero beat with nonzero payload");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        ndc.valid && ndc.saturated |->
            ndc.ndc_x == 16'h7FFF || ndc.ndc_x == 16'h8000 ||
            ndc.ndc_y == 16'h7FFF || ndc.ndc_y == 16'h8000 ||
            ndc.ndc_z == 16'h7FFF || ndc.ndc_z == 16'h8000)
        else $error("saturated flag without a clamped lane");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT-1] && !dst_reg[N_DIV].wz |->
            (dst_reg[N_DIV].ovf[0] || RW'(dst_reg[N_DIV].den) > dst_reg[N_DIV].rem[0]) &&
            (dst_reg[N_DIV].ovf[1] || RW'(dst_reg[N_DIV].den) > dst_reg[N_DIV].rem[1]) &&
            (dst_reg[N_DIV].ovf[2] || RW'(dst_reg[N_DIV].den) > dst_reg[N_DIV].rem[2]))
        else $error("divider remainder not below divisor");

    a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        ndc.valid && !ndc.ready |=> ndc.valid)
        else $error("output beat dropped under stall");

endmodule

`default_nettype wire
